[sv/uer_pkg.sv]
// ----------------------------------------------------------------------------
// uer_pkg
// shared widths, register map, phase codes and types of the echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int TICK_W      = 17;                    // echo tick counter
    localparam int TRIG_W      = 16;                    // trigger tick counter
    localparam int DATA_W      = 32;                    // q16.16 values, apb data
    localparam int PROD_W      = DATA_W + TICK_W + 1;   // signed acc times unsigned ticks
    localparam int SUM_W       = PROD_W + 1;            // product plus coefficient
    localparam int PHASE_W     = 2;

    localparam int NUM_REGS    = 6;
    localparam int REG_IDX_W   = 3;
    localparam int ADDR_W      = REG_IDX_W + 2;         // byte address, 4 bytes a register

    localparam int COEF_REGS   = 4;
    localparam int COEF_IDX_W  = 2;
    localparam int COEF_COUNT_DEF = 4;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ECHO_LIMIT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ZERO     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ONE      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_TWO      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEF_THREE    = 3'd5;

    // register reset values
    localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 16'd271;
    localparam logic [TICK_W-1:0] ECHO_LIMIT_RST    = 17'd131070;
    localparam logic [DATA_W-1:0] COEF_ZERO_RST     = 32'd0;
    localparam logic [DATA_W-1:0] COEF_ONE_RST      = 32'd65536;
    localparam logic [DATA_W-1:0] COEF_TWO_RST      = 32'd0;
    localparam logic [DATA_W-1:0] COEF_THREE_RST    = 32'd0;

    // ranging phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TRIG = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT = 2'd2;
    localparam logic [PHASE_W-1:0] PH_MEAS = 2'd3;

    typedef logic [COEF_REGS-1:0][DATA_W-1:0] coef_bank_t;

    typedef struct packed {
        logic [TRIG_W-1:0] trigger_ticks;
        logic [TICK_W-1:0] echo_limit;
        coef_bank_t        coefs;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hrn_status_t;

endpackage

[sv/ultrasonic_echo_ranger.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// ultrasonic ranging controller with polynomial distance calibration
// ----------------------------------------------------------------------------
// usage
//   one input transfer (s_start_req, s_echo) per timer tick, one result
//   transfer per tick on the m_ channel with the phase, trigger level, the
//   last echo width, the last calibrated distance and the done and timeout
//   flags as they stand after that tick
//   configuration goes through the apb port while no tick is in flight
// sequencing
//   an ordinary tick goes through the pending stage into the output register;
//   s_ready returns as the output register takes it, so no new tick is taken
//   before the last one's result has left the pending stage
//   a tick that ends an echo runs the horner sequence on the shared
//   multiplier, a multiply state and an add-saturate state per coefficient
//   step; its result then waits in the pending stage like any other
// reset
//   aresetn low puts the ranger idle, clears counters and held results and
//   loads the register defaults
// stalls
//   a result waits in the output register while m_ready is low; the next tick
//   is still taken and worked, and its result waits in the pending stage
//   until the output register frees
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COEF_COUNT = COEF_COUNT_DEF
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // apb configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    // tick input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_start_req,
    input  logic                     s_echo,
    // result output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_trigger_level,
    output logic [PHASE_W-1:0]       m_phase,
    output logic [TICK_W-1:0]        m_echo_ticks,
    output logic signed [DATA_W-1:0] m_distance,
    output logic                     m_done_res,
    output logic                     m_timeout
);

    // sequencer codes
    localparam logic [1:0] SEQ_IDLE = 2'd0;   // ready for a tick
    localparam logic [1:0] SEQ_CALC = 2'd1;   // horner evaluation running
    localparam logic [1:0] SEQ_PEND = 2'd2;   // result waiting for the output register

    cfg_t                     cfg;
    hrn_status_t              hrn_status;
    logic signed [DATA_W-1:0] hrn_result;
    logic                     hrn_start;

    logic [1:0]               seq_reg, seq_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [TRIG_W-1:0]        trig_cnt_reg, trig_cnt_next;
    logic [TICK_W-1:0]        echo_cnt_reg, echo_cnt_next;
    logic                     echo_prev_reg;
    logic [TICK_W-1:0]        ticks_held_reg, ticks_held_next;
    logic signed [DATA_W-1:0] distance_held_reg;
    logic                     done_pend_reg, done_next;
    logic                     tmo_pend_reg, tmo_next;

    logic                     m_valid_reg;
    logic                     m_trigger_level_reg;
    logic [PHASE_W-1:0]       m_phase_reg;
    logic [TICK_W-1:0]        m_echo_ticks_reg;
    logic signed [DATA_W-1:0] m_distance_reg;
    logic                     m_done_res_reg;
    logic                     m_timeout_reg;

    logic                     in_xfer;
    logic                     out_load;

    uer_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uer_horner #(
        .COEF_COUNT (COEF_COUNT)
    ) u_horner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hrn_start),
        .ticks   (echo_cnt_reg),
        .coefs   (cfg.coefs),
        .result  (hrn_result),
        .status  (hrn_status)
    );

    assign s_ready  = (seq_reg == SEQ_IDLE);
    assign in_xfer  = s_valid & s_ready;
    // output register takes the pending result once it is free or being drained
    assign out_load = (seq_reg == SEQ_PEND) & (~m_valid_reg | m_ready);

    // tick update of the ranging state
    always_comb begin
        phase_next      = phase_reg;
        trig_cnt_next   = trig_cnt_reg;
        echo_cnt_next   = echo_cnt_reg;
        ticks_held_next = ticks_held_reg;
        done_next       = 1'b0;
        tmo_next        = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (s_start_req) begin
                    phase_next    = PH_TRIG;
                    trig_cnt_next = TRIG_W'(1);
                end
            end
            PH_TRIG: begin
                // a zero length behaves as one tick
                if (trig_cnt_reg >= cfg.trigger_ticks) begin
                    phase_next    = PH_WAIT;
                    trig_cnt_next = '0;
                end else begin
                    trig_cnt_next = trig_cnt_reg + 1'b1;
                end
            end
            PH_WAIT: begin
                // only a genuine rising edge starts the count
                if (s_echo && !echo_prev_reg) begin
                    phase_next    = PH_MEAS;
                    echo_cnt_next = TICK_W'(1);
                end
            end
            PH_MEAS: begin
                if (!s_echo) begin
                    ticks_held_next = echo_cnt_reg;
                    done_next       = 1'b1;
                    phase_next      = PH_IDLE;
                end else if (echo_cnt_reg >= cfg.echo_limit) begin
                    // over-long echo, held results stay as they were
                    tmo_next   = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    echo_cnt_next = echo_cnt_reg + 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign hrn_start = in_xfer & done_next;

    // sequencer
    always_comb begin
        seq_next = seq_reg;
        case (seq_reg)
            SEQ_IDLE: begin
                if (in_xfer) begin
                    seq_next = done_next ? SEQ_CALC : SEQ_PEND;
                end
            end
            SEQ_CALC: begin
                if (hrn_status.done) begin
                    seq_next = SEQ_PEND;
                end
            end
            SEQ_PEND: begin
                if (out_load) begin
                    seq_next = SEQ_IDLE;
                end
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg           <= SEQ_IDLE;
            phase_reg         <= PH_IDLE;
            trig_cnt_reg      <= '0;
            echo_cnt_reg      <= '0;
            echo_prev_reg     <= 1'b0;
            ticks_held_reg    <= '0;
            distance_held_reg <= '0;
            done_pend_reg     <= 1'b0;
            tmo_pend_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            seq_reg <= seq_next;
            if (in_xfer) begin
                phase_reg      <= phase_next;
                trig_cnt_reg   <= trig_cnt_next;
                echo_cnt_reg   <= echo_cnt_next;
                echo_prev_reg  <= s_echo;
                ticks_held_reg <= ticks_held_next;
                done_pend_reg  <= done_next;
                tmo_pend_reg   <= tmo_next;
            end
            if (seq_reg == SEQ_CALC && hrn_status.done) begin
                distance_held_reg <= hrn_result;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_trigger_level_reg <= (phase_reg == PH_TRIG);
            m_phase_reg         <= phase_reg;
            m_echo_ticks_reg    <= ticks_held_reg;
            m_distance_reg      <= distance_held_reg;
            m_done_res_reg      <= done_pend_reg;
            m_timeout_reg       <= tmo_pend_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_trigger_level = m_trigger_level_reg;
    assign m_phase         = m_phase_reg;
    assign m_echo_ticks    = m_echo_ticks_reg;
    assign m_distance      = m_distance_reg;
    assign m_done_res      = m_done_res_reg;
    assign m_timeout       = m_timeout_reg;

    // no new tick while the evaluator still works
    a_ready_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !hrn_status.busy)
        else $error("tick taken while horner unit busy");

    // evaluator finishes only while the sequencer waits for it
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        hrn_status.done |-> (seq_reg == SEQ_CALC))
        else $error("horner result outside calculation");

    // a finished or aborted measurement always lands in idle
    a_end_is_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_done_res || m_timeout)) |-> (m_phase == PH_IDLE))
        else $error("measurement end without idle phase");

    // completion and abort are exclusive
    a_done_tmo_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_done_res && m_timeout))
        else $error("done and timeout on the same tick");

    // a started evaluation keeps the unit busy on the next cycle
    a_calc_length: assert property (@(posedge aclk) disable iff (!aresetn)
        hrn_start |=> hrn_status.busy)
        else $error("horner unit did not start");

endmodule

[sv/uer_regs.sv]
// ----------------------------------------------------------------------------
// uer_regs
// apb configuration registers: trigger length, echo limit, four coefficients
// ----------------------------------------------------------------------------
module uer_regs
    import uer_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [TRIG_W-1:0]    trigger_ticks_reg;
    logic [TICK_W-1:0]    echo_limit_reg;
    coef_bank_t           coefs_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            echo_limit_reg    <= ECHO_LIMIT_RST;
            coefs_reg[0]      <= COEF_ZERO_RST;
            coefs_reg[1]      <= COEF_ONE_RST;
            coefs_reg[2]      <= COEF_TWO_RST;
            coefs_reg[3]      <= COEF_THREE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TRIGGER_TICKS: trigger_ticks_reg <= pwdata[TRIG_W-1:0];
                REG_ECHO_LIMIT:    echo_limit_reg    <= pwdata[TICK_W-1:0];
                REG_COEF_ZERO:     coefs_reg[0]      <= pwdata;
                REG_COEF_ONE:      coefs_reg[1]      <= pwdata;
                REG_COEF_TWO:      coefs_reg[2]      <= pwdata;
                REG_COEF_THREE:    coefs_reg[3]      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TRIGGER_TICKS: prdata = DATA_W'(trigger_ticks_reg);
            REG_ECHO_LIMIT:    prdata = DATA_W'(echo_limit_reg);
            REG_COEF_ZERO:     prdata = coefs_reg[0];
            REG_COEF_ONE:      prdata = coefs_reg[1];
            REG_COEF_TWO:      prdata = coefs_reg[2];
            REG_COEF_THREE:    prdata = coefs_reg[3];
            default:           prdata = '0;
        endcase
    end

    assign cfg.trigger_ticks = trigger_ticks_reg;
    assign cfg.echo_limit    = echo_limit_reg;
    assign cfg.coefs         = coefs_reg;

endmodule

[sv/uer_horner.sv]
// ----------------------------------------------------------------------------
// uer_horner
// iterative horner evaluation: one shared multiplier, then add and saturate
// ----------------------------------------------------------------------------
module uer_horner
    import uer_pkg::*;
#(
    parameter int COEF_COUNT = COEF_COUNT_DEF
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [TICK_W-1:0]        ticks,
    input  coef_bank_t               coefs,
    output logic signed [DATA_W-1:0] result,
    output hrn_status_t              status
);

    localparam int KW = (COEF_COUNT > 2) ? $clog2(COEF_COUNT - 1) : 1;

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_MUL  = 2'd1;
    localparam logic [1:0] H_ADD  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [KW-1:0]            k_reg, k_next;
    logic                     done_reg, done_next;
    logic [TICK_W-1:0]        t_reg;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [SUM_W-1:0]  sum;
    logic [DATA_W-1:0]        coef_sel;
    logic signed [DATA_W-1:0] acc_sat;

    assign coef_sel  = coefs[COEF_IDX_W'(k_reg)];
    assign prod_full = acc_reg * $signed({1'b0, t_reg});
    assign sum       = $signed({prod_reg[PROD_W-1], prod_reg})
                     + $signed({{(SUM_W-DATA_W){coef_sel[DATA_W-1]}}, coef_sel});

    // clamp to the signed 32-bit range when the upper bits disagree
    always_comb begin
        if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1) begin
            acc_sat = sum[DATA_W-1:0];
        end else if (sum[SUM_W-1]) begin
            acc_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        case (state_reg)
            H_IDLE: begin
                if (start) begin
                    acc_next   = coefs[COEF_IDX_W'(COEF_COUNT - 1)];
                    k_next     = KW'(COEF_COUNT - 2);
                    state_next = H_MUL;
                end
            end
            H_MUL: begin
                state_next = H_ADD;
            end
            H_ADD: begin
                acc_next = acc_sat;
                if (k_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end else begin
                    k_next     = k_reg - 1'b1;
                    state_next = H_MUL;
                end
            end
            default: begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (state_reg == H_IDLE && start) begin
            t_reg <= ticks;
        end
        if (state_reg == H_MUL) begin
            prod_reg <= prod_full;
        end
    end

    assign result      = acc_reg;
    assign status.busy = (state_reg != H_IDLE) | done_reg;
    assign status.done = done_reg;

endmodule

[tb/ultrasonic_echo_ranger_tb.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb
// self-checking bench for the ultrasonic echo ranger
// ----------------------------------------------------------------------------
// a stimulus table walks the ranger through reset values, zero trigger and
// zero echo limits, echoes out of phase, ignored starts, unmapped register
// writes, done and timeout ticks and saturating horner steps; phases of random
// ticks follow, each under its own register setting and idling pattern, with
// the tick stream steered by the predicted phase so that most ticks complete
// whole measurements; every result transfer is checked field by field against
// a cycle-free model of the ranger kept inside the bench
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
    import uer_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_TICKS  = 72;
    localparam int SETTLE       = 4;        // cycles left after the last result
    localparam int END_WAIT     = 10000;

    // addresses past the register map, writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam longint Q_MAX = 64'sh7FFF_FFFF;
    localparam longint Q_MIN = -64'sh8000_0000;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum logic [1:0] {ROW_CFG, ROW_TICK, ROW_KNOWN} row_kind_t;

    // one result transfer as the ranger reports it
    typedef struct packed {
        logic               trig;
        logic [PHASE_W-1:0] phase;
        logic [TICK_W-1:0]  ticks;
        logic [DATA_W-1:0]  distance;
        logic               done;
        logic               tmo;
    } ranging_t;

    // stimulus table row: a register write, or a tick that is either predicted
    // or carries its expected result typed in
    typedef struct packed {
        row_kind_t          kind;
        logic               st;
        logic               ec;
        logic [PHASE_W-1:0] ph;
        logic [TICK_W-1:0]  ticks;
        logic [DATA_W-1:0]  distance;
        logic               done;
        logic               tmo;
        logic [REG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]  val;
    } plan_row_t;

    localparam int PLAN_LEN = 33;

    // columns: kind, start, echo, phase, ticks, distance, done, timeout, reg, value
    plan_row_t plan [PLAN_LEN] = '{
        // reset values, echo while idle is ignored
        '{ROW_KNOWN, 0, 0, PH_IDLE, 0, 0, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 1, PH_IDLE, 0, 0, 0, 0, '0, '0},
        // zero trigger length, short echo limit, writes past the map
        '{ROW_CFG,   0, 0, PH_IDLE, 0, 0, 0, 0, REG_TRIGGER_TICKS, 32'd0},
        '{ROW_CFG,   0, 0, PH_IDLE, 0, 0, 0, 0, REG_ECHO_LIMIT,    32'd3},
        '{ROW_CFG,   0, 0, PH_IDLE, 0, 0, 0, 0, REG_SPARE_A,       32'hFFFF_FFFF},
        '{ROW_CFG,   0, 0, PH_IDLE, 0, 0, 0, 0, REG_SPARE_B,       32'h1234_5678},
        // trigger lasts one tick, echo already high is no edge
        '{ROW_KNOWN, 1, 1, PH_TRIG, 0, 0, 0, 0, '0, '0},
        '{ROW_KNOWN, 1, 1, PH_WAIT, 0, 0, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 1, PH_WAIT, 0, 0, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 0, PH_WAIT, 0, 0, 0, 0, '0, '0},
        // rising edge, start ignored while busy, three ticks then done
        '{ROW_KNOWN, 1, 1, PH_MEAS, 0, 0, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 1, PH_MEAS, 0, 0, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 1, PH_MEAS, 0, 0, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 0, PH_IDLE, 3, 196608, 1, 0, '0, '0},
        // echo held past the limit, held results unchanged
        '{ROW_KNOWN, 1, 0, PH_TRIG, 3, 196608, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 0, PH_WAIT, 3, 196608, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 1, PH_MEAS, 3, 196608, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 1, PH_MEAS, 3, 196608, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 1, PH_MEAS, 3, 196608, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 1, PH_IDLE, 3, 196608, 0, 1, '0, '0},
        // zero echo limit aborts on the high tick after the rising edge
        '{ROW_CFG,   0, 0, PH_IDLE, 0, 0, 0, 0, REG_ECHO_LIMIT,    32'd0},
        '{ROW_CFG,   0, 0, PH_IDLE, 0, 0, 0, 0, REG_COEF_THREE,    32'h7FFF_FFFF},
        '{ROW_CFG,   0, 0, PH_IDLE, 0, 0, 0, 0, REG_COEF_ZERO,     32'h8000_0000},
        '{ROW_TICK,  1, 0, PH_IDLE, 0, 0, 0, 0, '0, '0},
        '{ROW_TICK,  0, 0, PH_IDLE, 0, 0, 0, 0, '0, '0},
        '{ROW_TICK,  0, 1, PH_IDLE, 0, 0, 0, 0, '0, '0},
        '{ROW_KNOWN, 0, 1, PH_IDLE, 3, 196608, 0, 1, '0, '0},
        // widest limit, extreme coefficients drive the horner steps into saturation
        '{ROW_CFG,   0, 0, PH_IDLE, 0, 0, 0, 0, REG_ECHO_LIMIT,    32'd131071},
        '{ROW_TICK,  1, 1, PH_IDLE, 0, 0, 0, 0, '0, '0},
        '{ROW_TICK,  0, 0, PH_IDLE, 0, 0, 0, 0, '0, '0},
        '{ROW_TICK,  0, 1, PH_IDLE, 0, 0, 0, 0, '0, '0},
        '{ROW_TICK,  0, 1, PH_IDLE, 0, 0, 0, 0, '0, '0},
        '{ROW_TICK,  0, 0, PH_IDLE, 0, 0, 0, 0, '0, '0}
    };

    // clock, reset and every block input known from time zero
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [DATA_W-1:0]    pwdata      = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_start_req = 1'b0;
    logic                 s_echo      = 1'b0;
    logic                 m_ready     = 1'b0;

    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_trigger_level;
    logic [PHASE_W-1:0]   m_phase;
    logic [TICK_W-1:0]    m_echo_ticks;
    logic signed [DATA_W-1:0] m_distance;
    logic                 m_done_res;
    logic                 m_timeout;

    // idling knobs, percent of cycles
    int gap_pct   = 0;
    int stall_pct = 0;
    int mismatches = 0;

    // readings the ranger still owes, oldest first
    ranging_t expected_readings [$];

    // ranger model: configuration and state
    logic [TRIG_W-1:0]        cfg_trig  = 16'd271;
    logic [TICK_W-1:0]        cfg_limit = 17'd131070;
    logic signed [DATA_W-1:0] coef [COEF_REGS] = '{32'sd0, 32'sd65536, 32'sd0, 32'sd0};
    logic [PHASE_W-1:0]       ph         = PH_IDLE;
    logic [TRIG_W-1:0]        trig_cnt   = '0;
    logic [TICK_W-1:0]        echo_cnt   = '0;
    logic                     echo_last  = 1'b0;
    logic [TICK_W-1:0]        held_ticks = '0;
    logic signed [DATA_W-1:0] held_dist  = '0;

    ultrasonic_echo_ranger #(
        .COEF_COUNT      (COEF_COUNT_DEF)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_req     (s_start_req),
        .s_echo          (s_echo),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trigger_level (m_trigger_level),
        .m_phase         (m_phase),
        .m_echo_ticks    (m_echo_ticks),
        .m_distance      (m_distance),
        .m_done_res      (m_done_res),
        .m_timeout       (m_timeout)
    );

    always #5 aclk = ~aclk;

    // calibrated distance: horner's rule, each step exact then saturated
    function automatic logic signed [DATA_W-1:0] calibrate(input logic [TICK_W-1:0] t);
        logic signed [DATA_W-1:0] acc;
        longint                   tl;
        longint                   sum;
        tl  = t;
        acc = coef[COEF_COUNT_DEF-1];
        for (int k = COEF_COUNT_DEF - 2; k >= 0; k--) begin
            sum = longint'(acc) * tl + longint'(coef[k]);
            if (sum > Q_MAX) begin
                acc = 32'sh7FFF_FFFF;
            end else if (sum < Q_MIN) begin
                acc = 32'sh8000_0000;
            end else begin
                acc = sum[DATA_W-1:0];
            end
        end
        return acc;
    endfunction

    // one timer tick through the model, returns the reading after the update
    function automatic ranging_t range_step(input logic st, input logic ec);
        ranging_t r;
        r.done = 1'b0;
        r.tmo  = 1'b0;
        case (ph)
            PH_IDLE: begin
                if (st) begin
                    ph       = PH_TRIG;
                    trig_cnt = 16'd1;
                end
            end
            PH_TRIG: begin
                // a zero length behaves as one tick
                if (trig_cnt >= cfg_trig) begin
                    ph       = PH_WAIT;
                    trig_cnt = '0;
                end else begin
                    trig_cnt = trig_cnt + 1'b1;
                end
            end
            PH_WAIT: begin
                // only a true rising edge starts the count
                if (ec && !echo_last) begin
                    ph       = PH_MEAS;
                    echo_cnt = 17'd1;
                end
            end
            default: begin
                if (!ec) begin
                    held_ticks = echo_cnt;
                    held_dist  = calibrate(echo_cnt);
                    r.done     = 1'b1;
                    ph         = PH_IDLE;
                end else if (echo_cnt >= cfg_limit) begin
                    r.tmo = 1'b1;
                    ph    = PH_IDLE;
                end else begin
                    echo_cnt = echo_cnt + 1'b1;
                end
            end
        endcase
        echo_last  = ec;
        r.trig     = (ph == PH_TRIG);
        r.phase    = ph;
        r.ticks    = held_ticks;
        r.distance = held_dist;
        return r;
    endfunction

    // register write as the model sees it, unmapped indexes drop out
    function automatic void cfg_apply(input logic [REG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] val);
        case (idx)
            REG_TRIGGER_TICKS: cfg_trig  = val[TRIG_W-1:0];
            REG_ECHO_LIMIT:    cfg_limit = val[TICK_W-1:0];
            REG_COEF_ZERO:     coef[0]   = val;
            REG_COEF_ONE:      coef[1]   = val;
            REG_COEF_TWO:      coef[2]   = val;
            REG_COEF_THREE:    coef[3]   = val;
            default: ;
        endcase
    endfunction

    // apb write: setup cycle, access cycle, then release the bus
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        cfg_apply(idx, val);
    endtask

    // present one tick, with a random gap first, and hold it until the transfer
    task automatic send_tick(input logic st, input logic ec, input ranging_t want);
        expected_readings.push_back(want);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_req <= st;
        s_echo      <= ec;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and let every owed reading come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_trigger();
        logic [DATA_W-1:0] v;
        case ($urandom_range(3))
            0:       v = 32'd1;
            1:       v = 32'd0;
            default: v = $urandom_range(8, 2);
        endcase
        v[DATA_W-1:TRIG_W] = (DATA_W-TRIG_W)'($urandom());    // junk above the field is dropped
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] pick_limit();
        logic [DATA_W-1:0] v;
        case ($urandom_range(4))
            0:       v = 32'd1;
            1:       v = $urandom_range(40, 2);
            2:       v = 32'd131071;
            3:       v = 32'd0;
            default: v = $urandom_range(131071, 1);
        endcase
        v[DATA_W-1:TICK_W] = (DATA_W-TICK_W)'($urandom());
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] pick_coef();
        logic [DATA_W-1:0] v;
        case ($urandom_range(5))
            0:       v = '0;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h8000_0000;
            3:       v = $urandom();
            4:       v = $urandom_range(32'h0020_0000) - 32'h0010_0000;   // within +-16.0
            default: v = $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
        endcase
        return v;
    endfunction

    // echo width to aim for, now and then right at the limit or one past it
    function automatic int pick_len();
        int len;
        case ($urandom_range(9))
            0:       len = $urandom_range(600, 13);
            1:       len = (cfg_limit <= 600) ? int'(cfg_limit) + $urandom_range(1)
                                              : $urandom_range(12, 1);
            default: len = $urandom_range(12, 1);
        endcase
        return len;
    endfunction

    // receiver side: random back-pressure on the result channel
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker: every result transfer against the oldest owed reading
    always @(posedge aclk) begin : result_check
        ranging_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                $error("result transfer with no tick outstanding");
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                if (m_trigger_level !== want.trig) begin
                    $error("trigger_level: expected %0d, got %0d", want.trig, m_trigger_level);
                    mismatches++;
                end
                if (m_phase !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, m_phase);
                    mismatches++;
                end
                if (m_echo_ticks !== want.ticks) begin
                    $error("echo_ticks: expected %0d, got %0d", want.ticks, m_echo_ticks);
                    mismatches++;
                end
                if (m_distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", $signed(want.distance),
                           m_distance);
                    mismatches++;
                end
                if (m_done_res !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, m_done_res);
                    mismatches++;
                end
                if (m_timeout !== want.tmo) begin
                    $error("timeout: expected %0d, got %0d", want.tmo, m_timeout);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        ranging_t   known;
        logic       st;
        logic       ec;
        int         n;
        int         budget;
        int         start_pct;
        int         plan_len;
        idle_mode_t mode;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, register writes only once the ranger has gone quiet
        plan_len = 1;
        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG: begin
                    drain_results();
                    write_reg(plan[i].idx, plan[i].val);
                end
                ROW_KNOWN: begin
                    // model still steps so its state follows the ranger
                    void'(range_step(plan[i].st, plan[i].ec));
                    known = '{(plan[i].ph == PH_TRIG), plan[i].ph, plan[i].ticks,
                              plan[i].distance, plan[i].done, plan[i].tmo};
                    send_tick(plan[i].st, plan[i].ec, known);
                end
                default: begin
                    send_tick(plan[i].st, plan[i].ec, range_step(plan[i].st, plan[i].ec));
                end
            endcase
        end

        // random phases, each with a fresh register setting and idling pattern
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_results();
            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
                IDLE_SENDER:   begin gap_pct = 67; stall_pct = 0;  end
                IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 67; end
                default:       begin gap_pct = 22; stall_pct = 22; end
            endcase

            write_reg(REG_TRIGGER_TICKS, pick_trigger());
            write_reg(REG_ECHO_LIMIT, pick_limit());
            write_reg(REG_COEF_ZERO,  pick_coef());
            write_reg(REG_COEF_ONE,   pick_coef());
            write_reg(REG_COEF_TWO,   pick_coef());
            write_reg(REG_COEF_THREE, pick_coef());
            budget    = PHASE_TICKS;
            start_pct = 85;

            // keep going past the budget until the current measurement finishes
            n = 0;
            while (n < budget || ph != PH_IDLE) begin
                if (ph != PH_MEAS) begin
                    plan_len = pick_len();
                end
                st = ($urandom_range(1) != 0);
                case (ph)
                    PH_IDLE: begin
                        st = ($urandom_range(99) < start_pct);
                        ec = ($urandom_range(99) < 20);
                    end
                    PH_TRIG: ec = ($urandom_range(99) < 10);
                    PH_WAIT: ec = ($urandom_range(99) < 40);
                    default: begin
                        // hold echo for the planned width, with a little noise
                        ec = (echo_cnt < plan_len);
                        if ($urandom_range(99) < 4) begin
                            ec = !ec;
                        end
                    end
                endcase
                send_tick(st, ec, range_step(st, ec));
                n++;
            end
        end

        // wind down: no more ticks, wait for the owed readings with a bound
        s_valid <= 1'b0;
        for (int w = 0; w < END_WAIT && expected_readings.size() != 0; w++) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (expected_readings.size() != 0) begin
            $error("%0d readings never arrived", expected_readings.size());
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
sv/uer_pkg.sv
sv/uer_regs.sv
sv/uer_horner.sv
sv/ultrasonic_echo_ranger.sv
tb/ultrasonic_echo_ranger_tb.sv
